// ----- rtl/clr_pkg.sv -----
// ----------------------------------------------------------------------------
// Clipped line rasterizer package
// Shared widths, register indexes, outcode bits, clip operations and states.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int WIN_BITS           = 13;
  localparam int STRIDE_BITS        = 14;
  localparam int ADDR_BITS          = 25;
  localparam int COLOR_BITS         = 8;
  localparam int PROD_BITS          = 32;
  localparam int OC_BITS            = 4;
  localparam int CFG_INDEX_BITS     = 2;
  localparam int CFG_DATA_BITS      = STRIDE_BITS;
  localparam int OP_BITS            = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_STRIDE    = 2'd2;

  localparam logic [WIN_BITS-1:0]    WINDOW_WIDTH_RESET  = 13'd640;
  localparam logic [WIN_BITS-1:0]    WINDOW_HEIGHT_RESET = 13'd400;
  localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET    = 14'd640;

  localparam logic [OC_BITS-1:0] OC_LEFT   = 4'b1000;
  localparam logic [OC_BITS-1:0] OC_RIGHT  = 4'b0100;
  localparam logic [OC_BITS-1:0] OC_TOP    = 4'b0010;
  localparam logic [OC_BITS-1:0] OC_BOTTOM = 4'b0001;

  // clip operations in execution order: endpoint, then edge axis
  localparam logic [OP_BITS-1:0] OP_START_X = 2'd0;
  localparam logic [OP_BITS-1:0] OP_START_Y = 2'd1;
  localparam logic [OP_BITS-1:0] OP_END_X   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_END_Y   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CODE,
    ST_OP,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_ORDER,
    ST_SETUP
  } state_t;

endpackage

// ----- rtl/clipped_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Clipped line rasterizer
// Step transaction: pixel registered in the cycle after acceptance, one per
// cycle unless the output stalls. Start transaction: a rejected line returns
// to idle; each edge clip uses a restoring divider shared by up to four clips.
// Reset: registers 640/400/640, no line active.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer
  import clr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          mode,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [COLOR_BITS-1:0]         line_color,
  output logic                          pixel_valid,
  input  logic                          pixel_stall,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [ADDR_BITS-1:0]          pixel_address,
  output logic [COLOR_BITS-1:0]         pixel_color,
  output logic                          in_window,
  output logic                          last
);

  localparam int CW       = COORD_BITS;
  localparam int WD       = ((CW > WIN_BITS + 1) ? CW : WIN_BITS + 1) + 2;
  localparam int CNT_BITS = $clog2(PROD_BITS);

  localparam logic signed [WD-1:0] ONE_W     = WD'(1);
  localparam logic signed [CW-1:0] ONE_C     = CW'(1);
  localparam logic signed [CW-1:0] MINUS_ONE = {CW{1'b1}};
  localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(PROD_BITS - 1);

  function automatic logic [OC_BITS-1:0] outcode(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y,
                                                 input logic signed [WD-1:0] w,
                                                 input logic signed [WD-1:0] h);
    logic [OC_BITS-1:0] c;
    c = '0;
    if (x[CW-1]) c = c | OC_LEFT;
    if (WD'(x) >= w) c = c | OC_RIGHT;
    if (y[CW-1]) c = c | OC_TOP;
    if (WD'(y) >= h) c = c | OC_BOTTOM;
    return c;
  endfunction

  state_t state, state_next;

  logic [WIN_BITS-1:0]    win_w, win_h;
  logic [STRIDE_BITS-1:0] stride;
  logic                   line_active;

  logic signed [CW-1:0] sx, sy, ex, ey;
  logic [OC_BITS-1:0]   code_s, code_e;
  logic [OP_BITS-1:0]   op;
  logic [PROD_BITS-1:0] a32, b32, qreg;
  logic signed [WD-1:0] d_full;
  logic signed [CW-1:0] edge_c;
  logic [CW:0]          dvs;
  logic                 d_neg, q_neg;
  logic [CW-1:0]        rem;
  logic [CNT_BITS-1:0]  cnt;

  logic signed [CW-1:0] cur_x, cur_y, far_x;
  logic [CW-1:0]        ydist, major_dist, minor_dist;
  logic                 horiz, x_step_negative, major_is_y;
  logic [CW:0]          pixels_left;
  logic signed [CW:0]   error_accum;
  logic [COLOR_BITS-1:0] held_color;

  logic item_take, start_take, walk;

  logic signed [WD-1:0] w_ext, h_ext;
  logic [OC_BITS-1:0]   code_s_v, code_e_v;

  logic signed [CW-1:0] main, cross_v, o_main, o_cross;
  logic [OC_BITS-1:0]   code_sel;
  logic                 op_active, low_edge, go_mul;
  logic signed [WD-1:0] lim_ext, edge_v, a_v, b_v, d_v;

  logic [CW:0]          shifted;
  logic                 div_ge;
  logic [PROD_BITS-1:0] q_signed;

  logic                 wb_en;
  logic signed [CW-1:0] wb_main, wb_cross;

  logic                 y_swap, x_swap;
  logic                 x_neg, x_zero, y_major;
  logic [CW-1:0]        x_abs, major_v, minor_v;
  logic [CW:0]          pixels_v;
  logic                 x_step_v, major_is_y_v;

  logic signed [CW:0]   err1;
  logic                 err_neg, step_x, step_y;
  logic signed [CW-1:0] xs;
  logic [ADDR_BITS-1:0] y25, x25;
  logic [ADDR_BITS+STRIDE_BITS-1:0] addr_prod;
  logic                 inwin_v;

  // ---------------------------------------------------------------- control
  assign item_take  = item_valid && !item_stall;
  assign start_take = item_take && !mode;
  assign walk       = item_take && mode && line_active;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_take) state_next = ST_CODE;
      ST_CODE:  state_next = (|(code_s_v & code_e_v)) ? ST_IDLE : ST_OP;
      ST_OP: begin
        if (go_mul) state_next = ST_MUL;
        else if (op == OP_END_Y) state_next = ST_ORDER;
      end
      ST_MUL:   state_next = ST_ABS;
      ST_ABS:   state_next = ST_DIV;
      ST_DIV:   if (cnt == CNT_LAST) state_next = ST_FIX;
      ST_FIX:   state_next = (op == OP_END_Y) ? ST_ORDER : ST_OP;
      ST_ORDER: state_next = ST_SETUP;
      ST_SETUP: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE) || (pixel_valid && pixel_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_active <= 1'b0;
      pixel_valid <= 1'b0;
      win_w       <= WINDOW_WIDTH_RESET;
      win_h       <= WINDOW_HEIGHT_RESET;
      stride      <= ROW_STRIDE_RESET;
    end else begin
      state <= state_next;
      if (start_take) begin
        line_active <= 1'b0;
      end else if (state == ST_SETUP) begin
        line_active <= 1'b1;
      end else if (walk && (pixels_left == (CW+1)'(1))) begin
        line_active <= 1'b0;
      end
      if (walk) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_WINDOW_WIDTH:  win_w  <= cfg_data[WIN_BITS-1:0];
          CFG_WINDOW_HEIGHT: win_h  <= cfg_data[WIN_BITS-1:0];
          CFG_ROW_STRIDE:    stride <= cfg_data[STRIDE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- clipping
  assign w_ext    = WD'($signed({1'b0, win_w}));
  assign h_ext    = WD'($signed({1'b0, win_h}));
  assign code_s_v = outcode(sx, sy, w_ext, h_ext);
  assign code_e_v = outcode(ex, ey, w_ext, h_ext);

  always_comb begin
    unique case (op)
      OP_START_X: begin main = sx; cross_v = sy; o_main = ex; o_cross = ey; end
      OP_START_Y: begin main = sy; cross_v = sx; o_main = ey; o_cross = ex; end
      OP_END_X:   begin main = ex; cross_v = ey; o_main = sx; o_cross = sy; end
      OP_END_Y:   begin main = ey; cross_v = ex; o_main = sy; o_cross = sx; end
      default:    begin main = sx; cross_v = sy; o_main = ex; o_cross = ey; end
    endcase
    code_sel  = op[1] ? code_e : code_s;
    op_active = op[0] ? |(code_sel & (OC_TOP | OC_BOTTOM))
                      : |(code_sel & (OC_LEFT | OC_RIGHT));
    low_edge  = op[0] ? |(code_sel & OC_TOP) : |(code_sel & OC_LEFT);
    lim_ext   = op[0] ? h_ext : w_ext;
    edge_v    = low_edge ? '0 : lim_ext - ONE_W;
    a_v       = edge_v - WD'(main);
    b_v       = WD'(o_cross) - WD'(cross_v);
    d_v       = WD'(o_main) - WD'(main);
    go_mul    = op_active && (d_v != '0);
  end

  assign shifted  = {rem, qreg[PROD_BITS-1]};
  assign div_ge   = shifted >= dvs;
  assign q_signed = q_neg ? -qreg : qreg;

  always_comb begin
    wb_en    = 1'b0;
    wb_main  = CW'(edge_v);
    wb_cross = cross_v;
    if (state == ST_OP) begin
      wb_en = op_active && (d_v == '0);
    end else if (state == ST_FIX) begin
      wb_en    = 1'b1;
      wb_main  = edge_c;
      wb_cross = cross_v + $signed(CW'(q_signed));
    end
  end

  // ---------------------------------------------------------------- line setup
  always_comb begin
    y_swap  = ey < sy;
    x_swap  = ex < sx;
    x_neg   = far_x < cur_x;
    x_zero  = far_x == cur_x;
    x_abs   = x_neg ? CW'(cur_x - far_x) : CW'(far_x - cur_x);
    y_major = x_abs < ydist;
    if (horiz) begin
      major_v      = x_abs;
      minor_v      = '0;
      pixels_v     = {1'b0, x_abs} + (CW+1)'(1);
      major_is_y_v = 1'b0;
      x_step_v     = 1'b0;
    end else if (x_zero) begin
      major_v      = ydist;
      minor_v      = '0;
      pixels_v     = {1'b0, ydist} + (CW+1)'(1);
      major_is_y_v = 1'b1;
      x_step_v     = 1'b0;
    end else begin
      major_v      = y_major ? ydist : x_abs;
      minor_v      = y_major ? x_abs : ydist;
      pixels_v     = {1'b0, major_v};
      major_is_y_v = y_major;
      x_step_v     = x_neg;
    end
  end

  // ---------------------------------------------------------------- walk
  always_comb begin
    err1      = error_accum - $signed({1'b0, minor_dist});
    err_neg   = err1[CW];
    step_x    = major_is_y ? err_neg : 1'b1;
    step_y    = major_is_y ? 1'b1 : err_neg;
    xs        = x_step_negative ? MINUS_ONE : ONE_C;
    y25       = ADDR_BITS'(cur_y);
    x25       = ADDR_BITS'(cur_x);
    addr_prod = y25 * stride;
    inwin_v   = !cur_x[CW-1] && (WD'(cur_x) < w_ext) &&
                !cur_y[CW-1] && (WD'(cur_y) < h_ext);
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start_take) begin
          sx         <= start_x;
          sy         <= start_y;
          ex         <= end_x;
          ey         <= end_y;
          held_color <= line_color;
        end
        if (walk) begin
          pixel_x       <= cur_x;
          pixel_y       <= cur_y;
          pixel_address <= addr_prod[ADDR_BITS-1:0] + x25;
          pixel_color   <= held_color;
          in_window     <= inwin_v;
          last          <= pixels_left == (CW+1)'(1);
          pixels_left   <= pixels_left - (CW+1)'(1);
          error_accum   <= err_neg ? err1 + $signed({1'b0, major_dist}) : err1;
          if (step_x) cur_x <= cur_x + xs;
          if (step_y) cur_y <= cur_y + ONE_C;
        end
      end
      ST_CODE: begin
        code_s <= code_s_v;
        code_e <= code_e_v;
        op     <= OP_START_X;
      end
      ST_OP: begin
        a32    <= PROD_BITS'(a_v);
        b32    <= PROD_BITS'(b_v);
        d_full <= d_v;
        edge_c <= CW'(edge_v);
        if (!go_mul) op <= op + OP_BITS'(1);
      end
      ST_MUL: begin
        qreg  <= a32 * b32;
        d_neg <= d_full[WD-1];
        dvs   <= d_full[WD-1] ? (CW+1)'(-d_full) : (CW+1)'(d_full);
      end
      ST_ABS: begin
        q_neg <= qreg[PROD_BITS-1] ^ d_neg;
        qreg  <= qreg[PROD_BITS-1] ? -qreg : qreg;
        rem   <= '0;
        cnt   <= '0;
      end
      ST_DIV: begin
        rem  <= div_ge ? CW'(shifted - dvs) : CW'(shifted);
        qreg <= {qreg[PROD_BITS-2:0], div_ge};
        cnt  <= cnt + CNT_BITS'(1);
      end
      ST_FIX: begin
        op <= op + OP_BITS'(1);
      end
      ST_ORDER: begin
        horiz <= ey == sy;
        if (ey == sy) begin
          cur_x <= x_swap ? ex : sx;
          far_x <= x_swap ? sx : ex;
          cur_y <= sy;
          ydist <= '0;
        end else begin
          cur_x <= y_swap ? ex : sx;
          cur_y <= y_swap ? ey : sy;
          far_x <= y_swap ? sx : ex;
          ydist <= y_swap ? CW'(sy - ey) : CW'(ey - sy);
        end
      end
      ST_SETUP: begin
        major_dist      <= major_v;
        minor_dist      <= minor_v;
        pixels_left     <= pixels_v;
        major_is_y      <= major_is_y_v;
        x_step_negative <= x_step_v;
        error_accum     <= $signed({2'b00, major_v[CW-1:1]});
      end
      default: ;
    endcase

    if (wb_en) begin
      unique case (op)
        OP_START_X: begin sx <= wb_main; sy <= wb_cross; end
        OP_START_Y: begin sy <= wb_main; sx <= wb_cross; end
        OP_END_X:   begin ex <= wb_main; ey <= wb_cross; end
        OP_END_Y:   begin ey <= wb_main; ex <= wb_cross; end
        default: ;
      endcase
    end
  end

endmodule
